@@ rtl/sha1s_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1s_pkg
// shared types and constants of the streaming sha-1 hasher
// ----------------------------------------------------------------------------
package sha1s_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_hash;

    // input transfer: one message byte and/or end of message
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_item;

    // output transfer: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // control of the round unit
    typedef struct packed {
        logic       load;
        logic       step;
        logic [6:0] round;
    } t_round_ctl;

    // control of the schedule window
    typedef struct packed {
        logic push;
        logic step;
    } t_sched_ctl;

    localparam t_hash SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word SHA1_K0 = 32'h5A827999;
    localparam t_word SHA1_K1 = 32'h6ED9EBA1;
    localparam t_word SHA1_K2 = 32'h8F1BBCDC;
    localparam t_word SHA1_K3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [2:0] LAST_INDEX = 3'd4;

endpackage

@@ rtl/sha1s_sched.sv @@
// ----------------------------------------------------------------------------
// sha1s_sched
// 16-word message window: byte packing and rolling round schedule
// ----------------------------------------------------------------------------
module sha1s_sched
    import sha1s_pkg::*;
(
    input  logic       i_clk,
    input  t_sched_ctl i_ctl,
    input  logic [7:0] i_byte,
    output t_word      o_w
);

    logic [15:0][31:0] r_win;
    logic [15:0][31:0] n_win;
    t_word             new_w;

    // w[t+16] from the taps of the window that holds w[t] .. w[t+15]
    assign new_w = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign o_w   = r_win[0];

    always_comb begin
        n_win = r_win;
        if (i_ctl.push) begin
            for (int i = 0; i < 15; i++) begin
                n_win[i] = {r_win[i][23:0], r_win[i+1][31:24]};
            end
            n_win[15] = {r_win[15][23:0], i_byte};
        end else if (i_ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                n_win[i] = r_win[i+1];
            end
            n_win[15] = {new_w[30:0], new_w[31]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

@@ rtl/sha1s_round.sv @@
// ----------------------------------------------------------------------------
// sha1s_round
// shared sha-1 round unit: one round per stepped cycle on working variables
// ----------------------------------------------------------------------------
module sha1s_round
    import sha1s_pkg::*;
(
    input  logic       i_clk,
    input  t_round_ctl i_ctl,
    input  t_hash      i_hash,
    input  t_word      i_w,
    output t_hash      o_vars
);

    t_word r_a, r_b, r_c, r_d, r_e;
    t_word f, k, tmp;

    always_comb begin
        if (i_ctl.round < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = SHA1_K0;
        end else if (i_ctl.round < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = SHA1_K1;
        end else if (i_ctl.round < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = SHA1_K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = SHA1_K3;
        end
    end

    assign tmp    = {r_a[26:0], r_a[31:27]} + f + r_e + k + i_w;
    assign o_vars = {r_e, r_d, r_c, r_b, r_a};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_hash[0];
            r_b <= i_hash[1];
            r_c <= i_hash[2];
            r_d <= i_hash[3];
            r_e <= i_hash[4];
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= tmp;
        end
    end

endmodule

@@ rtl/sha1_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// streaming sha-1: bytes in, five digest words out per message
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one transfer
//   per byte; has_byte marks a real byte, is_last ends the message (a last
//   transfer without a byte is allowed, so an empty message can be hashed).
//   output channel (o_out_valid / i_out_ready / o_out_data) gives the five
//   digest words, word_index 0 (most significant) first, last_word on 4.
// flow:
//   a byte that fills the 64-byte block goes through the push, 80 rounds
//   on the single shared round unit and the hash update.
//   the last transfer then feeds padding bytes through the same byte path,
//   one per cycle, runs one or two more compressions and presents the
//   digest.
//   o_in_ready is high only while the block waits for input.
// stall: the digest words stay on the port until each transfer happens.
// reset: initial vector loaded, byte and bit counts cleared, no output.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_unit
    import sha1s_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_FINAL,
        S_OUT
    } t_state;

    // padding phases: marker byte, zero fill, 64-bit length
    typedef enum logic [1:0] {
        PAD_MARKER,
        PAD_ZERO,
        PAD_LEN
    } t_pad;

    t_state      r_state,  n_state;
    t_pad        r_pad,    n_pad;
    logic        r_ending, n_ending;
    logic [5:0]  r_cnt,    n_cnt;
    logic [63:0] r_bits,   n_bits;
    logic [6:0]  r_round,  n_round;
    t_hash       r_hash,   n_hash;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_odata,  n_odata;

    t_sched_ctl  sched_ctl;
    t_round_ctl  round_ctl;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    logic [7:0]  len_byte;
    logic [2:0]  next_idx;
    t_word       sched_w;
    t_hash       vars;
    logic        in_xfer;
    logic        out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_ovalid && i_out_ready;
    assign next_idx = r_odata.word_index + 3'd1;

    // length bytes go out big-endian, byte 56 of the block is the top byte
    assign len_byte = r_bits[{~r_cnt[2:0], 3'b000} +: 8];

    always_comb begin
        unique case (r_pad)
            PAD_MARKER: pad_byte = PAD_MARK;
            PAD_ZERO:   pad_byte = (r_cnt == LEN_POS) ? len_byte : 8'h00;
            PAD_LEN:    pad_byte = len_byte;
            default:    pad_byte = 8'h00;
        endcase
    end

    assign push_byte = (r_state == S_IDLE) ? i_in_data.data_byte : pad_byte;

    sha1s_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_byte (push_byte),
        .o_w    (sched_w)
    );

    sha1s_round u_round (
        .i_clk  (i_clk),
        .i_ctl  (round_ctl),
        .i_hash (r_hash),
        .i_w    (sched_w),
        .o_vars (vars)
    );

    always_comb begin
        n_state   = r_state;
        n_pad     = r_pad;
        n_ending  = r_ending;
        n_cnt     = r_cnt;
        n_bits    = r_bits;
        n_round   = r_round;
        n_hash    = r_hash;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        sched_ctl = '0;
        round_ctl = '{load: 1'b0, step: 1'b0, round: r_round};

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_ending = i_in_data.is_last;
                    n_pad    = PAD_MARKER;
                    if (i_in_data.has_byte) begin
                        sched_ctl.push = 1'b1;
                        n_bits         = r_bits + 64'd8;
                        n_cnt          = r_cnt + 6'd1;
                    end
                    if (i_in_data.has_byte && (&r_cnt)) begin
                        // block full: start the compression
                        round_ctl.load = 1'b1;
                        n_state        = S_COMP;
                    end else if (i_in_data.is_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                sched_ctl.push = 1'b1;
                n_cnt          = r_cnt + 6'd1;
                if (r_pad == PAD_MARKER) begin
                    n_pad = PAD_ZERO;
                end else if (r_pad == PAD_ZERO && r_cnt == LEN_POS) begin
                    n_pad = PAD_LEN;
                end
                if (&r_cnt) begin
                    round_ctl.load = 1'b1;
                    n_state        = S_COMP;
                end
            end
            S_COMP: begin
                sched_ctl.step = 1'b1;
                round_ctl.step = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = S_FINAL;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_FINAL: begin
                for (int i = 0; i < 5; i++) begin
                    n_hash[i] = r_hash[i] + vars[i];
                end
                if (!r_ending) begin
                    n_state = S_IDLE;
                end else if (r_pad == PAD_LEN) begin
                    // length went into this block: digest is complete
                    n_state  = S_OUT;
                    n_ovalid = 1'b1;
                    n_odata  = '{digest_word: n_hash[0], word_index: '0,
                                 last_word: 1'b0};
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    if (r_odata.word_index == LAST_INDEX) begin
                        // message done: fresh state for the next one
                        n_ovalid = 1'b0;
                        n_hash   = SHA1_IV;
                        n_bits   = '0;
                        n_cnt    = '0;
                        n_ending = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_odata = '{digest_word: r_hash[next_idx],
                                    word_index: next_idx,
                                    last_word: (next_idx == LAST_INDEX)};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pad    <= PAD_MARKER;
            r_ending <= 1'b0;
            r_cnt    <= '0;
            r_bits   <= '0;
            r_round  <= '0;
            r_hash   <= SHA1_IV;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pad    <= n_pad;
            r_ending <= n_ending;
            r_cnt    <= n_cnt;
            r_bits   <= n_bits;
            r_round  <= n_round;
            r_hash   <= n_hash;
            r_ovalid <= n_ovalid;
        end
        r_odata <= n_odata;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

@@ rtl/sha1s_checker.sv @@
// ----------------------------------------------------------------------------
// sha1s_checker
// port-level checks of the streaming sha-1 hasher
// ----------------------------------------------------------------------------
module sha1s_checker
    import sha1s_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // no input taken while a digest is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest pending");

    // digest words come in order without gaps
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_word) |=>
        (o_out_valid &&
         o_out_data.word_index == $past(o_out_data.word_index) + 3'd1))
        else $error("digest word order broken");

    // last flag marks exactly the final word
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_word == (o_out_data.word_index == LAST_INDEX)))
        else $error("last_word mismatch");

    // after the final word the block goes back to taking input
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_word) |=>
        (!o_out_valid && o_in_ready))
        else $error("not idle after digest");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output changed while stalled");

endmodule

bind sha1_stream_hasher_unit sha1s_checker u_sha1s_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks sha1_stream_hasher_unit against a sha-1 predictor held in the bench
// ----------------------------------------------------------------------------
// a directed set of short messages (empty, one byte, "abc", bytes without
// has_byte) is followed by random messages whose lengths favor the padding
// and block boundaries. every input transfer is fed to the predictor, and
// each digest word transfer is checked against the oldest predicted word.
// both channels idle in random bursts. once the receiver holds off long
// enough for the hasher to stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import sha1s_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 300;   // covers the worst digest latency
    localparam int QUIET_TAIL   = 40;    // last items go through with no idling
    localparam int TOTAL_ITEMS  = 420;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    sha1_stream_hasher_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // items waiting for the driver, digest words waiting for the hasher
    t_in_item  pending_items[$];
    t_out_item due_words[$];

    // predictor state: chaining value, partial block, lengths
    t_word       hash_st[5];
    t_word       blk_words[16];
    int unsigned blk_fill;
    logic [63:0] msg_bit_len;

    // handshake bookkeeping
    logic        in_taken;
    int unsigned in_xfers;
    int unsigned in_gap;
    int unsigned out_gap;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned idle_cycles;
    int unsigned mismatches;

    // no idling near the end of the stimulus
    function automatic logic quiet();
        return pending_items.size() < QUIET_TAIL;
    endfunction

    function automatic t_word rotl(input t_word x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic t_in_item mk_item(input logic [7:0] d, input logic h,
                                         input logic l);
        t_in_item it;
        it.data_byte = d;
        it.has_byte  = h;
        it.is_last   = l;
        return it;
    endfunction

    task automatic sha1_reload_iv();
        int i;
        for (i = 0; i < 5; i++) hash_st[i] = SHA1_IV[i];
        blk_fill    = 0;
        msg_bit_len = '0;
    endtask

    // 80-round compression over the full block, fully expanded schedule
    task automatic sha1_compress();
        t_word w[80];
        t_word a, b, c, d, e, f, k, tmp;
        int    r;
        a = hash_st[0];
        b = hash_st[1];
        c = hash_st[2];
        d = hash_st[3];
        e = hash_st[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                w[r] = blk_words[r];
            end else begin
                w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = SHA1_K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = SHA1_K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = SHA1_K2;
            end else begin
                f = b ^ c ^ d;
                k = SHA1_K3;
            end
            tmp = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        hash_st[0] += a;
        hash_st[1] += b;
        hash_st[2] += c;
        hash_st[3] += d;
        hash_st[4] += e;
    endtask

    // big-endian byte packing, compress when the block is full
    task automatic sha1_push_byte(input logic [7:0] b);
        int unsigned sh;
        sh = (3 - blk_fill % 4) * 8;
        blk_words[blk_fill / 4][sh +: 8] = b;
        blk_fill++;
        if (blk_fill == 64) begin
            sha1_compress();
            blk_fill = 0;
        end
    endtask

    // one accepted input transfer: append byte, on last pad and queue digest
    task automatic sha1_absorb_item(input t_in_item it);
        t_out_item w;
        int        i;
        if (it.has_byte) begin
            msg_bit_len += 64'd8;
            sha1_push_byte(it.data_byte);
        end
        if (it.is_last) begin
            sha1_push_byte(PAD_MARK);
            while (blk_fill != LEN_POS) sha1_push_byte(8'h00);
            for (i = 7; i >= 0; i--) sha1_push_byte(msg_bit_len[i*8 +: 8]);
            for (i = 0; i < 5; i++) begin
                w.digest_word = hash_st[i];
                w.word_index  = 3'(i);
                w.last_word   = (3'(i) == LAST_INDEX);
                due_words.push_back(w);
            end
            sha1_reload_iv();
        end
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input transfer: feed predictor, tell the driver at the next falling edge
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            sha1_absorb_item(in_data);
            in_taken = 1'b1;
            in_xfers++;
        end
    end

    // output transfer: compare with the oldest predicted digest word
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected digest word %h index %0d last %b",
                             out_data.digest_word, out_data.word_index,
                             out_data.last_word);
                end
            end else begin
                want = due_words.pop_front();
                if (out_data.digest_word !== want.digest_word ||
                    out_data.word_index !== want.word_index ||
                    out_data.last_word !== want.last_word) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("digest word mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 want.digest_word, want.word_index, want.last_word,
                                 out_data.digest_word, out_data.word_index,
                                 out_data.last_word);
                    end
                end
            end
        end
    end

    // driver: holds an item until it is taken, random idle bursts between items
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (in_gap != 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                if (!quiet() && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(1, 19) - 1;
                    in_valid <= 1'b0;
                end else begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off while a digest
    // is pending so the hasher backs up and drops o_in_ready
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!hold_done && in_xfers > 40 && due_words.size() >= 5) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (out_gap != 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else if (!quiet() && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          boundary_lens[8];
        int          len;
        int          j;
        logic        byte_last;
        boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        in_taken    = 1'b0;
        in_xfers    = 0;
        in_gap      = 0;
        out_gap     = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        idle_cycles = 0;
        mismatches  = 0;
        blk_words   = '{default: '0};
        sha1_reload_iv();

        // directed: no byte and not last is a no-op
        pending_items.push_back(mk_item(8'hA5, 1'b0, 1'b0));
        // empty message
        pending_items.push_back(mk_item(8'h00, 1'b0, 1'b1));
        // byte and last together, field extremes
        pending_items.push_back(mk_item(8'hFF, 1'b1, 1'b1));
        pending_items.push_back(mk_item(8'h00, 1'b1, 1'b1));
        // "abc"
        pending_items.push_back(mk_item(8'h61, 1'b1, 1'b0));
        pending_items.push_back(mk_item(8'h62, 1'b1, 1'b0));
        pending_items.push_back(mk_item(8'h63, 1'b1, 1'b1));
        // last without byte, data_byte set but ignored
        pending_items.push_back(mk_item(8'h00, 1'b1, 1'b0));
        pending_items.push_back(mk_item(8'hFF, 1'b1, 1'b0));
        pending_items.push_back(mk_item(8'h5A, 1'b0, 1'b1));
        // ignored item in the middle of a message
        pending_items.push_back(mk_item(8'h80, 1'b1, 1'b0));
        pending_items.push_back(mk_item(8'hFF, 1'b0, 1'b0));
        pending_items.push_back(mk_item(8'h7F, 1'b1, 1'b1));

        // random messages, lengths often at padding and block boundaries
        while (pending_items.size() < TOTAL_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                len = boundary_lens[$urandom_range(0, 7)];
            end else begin
                len = $urandom_range(0, 20);
            end
            byte_last = (len != 0) && ($urandom_range(0, 1) == 1);
            for (j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_items.push_back(mk_item(8'($urandom), 1'b0, 1'b0));
                end
                pending_items.push_back(mk_item(8'($urandom), 1'b1,
                                                byte_last && j == len - 1));
            end
            if (!byte_last) begin
                pending_items.push_back(mk_item(8'($urandom), 1'b0, 1'b1));
            end
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // all items taken, all digests back, then let stray output show up
        while (pending_items.size() != 0 || in_valid) @(posedge clk);
        while (due_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && due_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
